### sv/segment_intersection_2d_core_assert.svh
// Assertion macros for the segment intersection core.
`ifndef SEGMENT_INTERSECTION_2D_CORE_ASSERT_SVH
`define SEGMENT_INTERSECTION_2D_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SI2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define SI2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SI2D_ASSERT_NOW(lbl, ante, cons, msg)
`define SI2D_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/si2d_pkg.sv
// Shared types, widths and helpers for the segment intersection core.
`timescale 1ns / 1ps
package si2d_pkg;
  localparam int CW      = 16;            // coordinate width, Q12.4
  localparam int IN_FRAC = 4;
  localparam int OUT_FRAC = 12;
  localparam int OW      = 28;            // output coordinate width
  localparam int DXW     = CW + 1;        // endpoint difference
  localparam int CAW     = CW + DXW + 1;  // line constant
  localparam int DW      = 2 * DXW + 1;   // determinant
  localparam int NW      = CAW + DXW + 1; // numerators and bounds
  localparam int SH      = OUT_FRAC - IN_FRAC;
  localparam int RW      = NW + SH;       // divider remainder
  localparam int QW      = CW + SH;       // quotient magnitude
  localparam int GEO_ST  = 4;             // geometry stages
  localparam int LAT     = GEO_ST + QW + 1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DXW-1:0] dx_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } pts_t;

  typedef struct packed {
    pts_t p;
    logic vert;
  } seg_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ONE,
    MODE_BOTH
  } mode_t;

  // Result of the geometry pipe, handed to the dividers.
  typedef struct packed {
    logic          hit;
    logic          x_neg;
    logic          y_neg;
    logic [NW-1:0] x_mag;
    logic [NW-1:0] y_mag;
    logic [DW-1:0] d_mag;
  } geo_t;

  // Tag that rides alongside the dividers.
  typedef struct packed {
    logic hit;
    logic x_neg;
    logic y_neg;
  } side_t;

  function automatic seg_t norm_seg(pts_t p);
    seg_t   s;
    coord_t t;
    s.p = p;
    if (p.x1 < p.x0) begin
      s.p.x0 = p.x1; s.p.x1 = p.x0;
      s.p.y0 = p.y1; s.p.y1 = p.y0;
    end
    s.vert = (s.p.x0 == s.p.x1);
    if (s.vert && (s.p.y1 < s.p.y0)) begin
      t = s.p.y0; s.p.y0 = s.p.y1; s.p.y1 = t;
    end
    return s;
  endfunction
endpackage

### sv/si2d_geom.sv
// Four-stage geometry pipe: normalize, line terms, numerators, hit test.
`timescale 1ns / 1ps
module si2d_geom (
  input  logic             clk,
  input  logic             en,
  input  si2d_pkg::pts_t   a,
  input  si2d_pkg::pts_t   b,
  output si2d_pkg::geo_t   g
);
  localparam int NW = si2d_pkg::NW;
  localparam int DW = si2d_pkg::DW;
  localparam int CAW = si2d_pkg::CAW;
  localparam int DXW = si2d_pkg::DXW;

  // stage 1: order endpoints, differences, vertical selection
  si2d_pkg::seg_t  sa, sb, s1_a, s1_b;
  si2d_pkg::pts_t  lp, vp, s1_l, s1_v;
  si2d_pkg::dx_t   s1_adx, s1_ady, s1_bdx, s1_bdy, s1_ldx, s1_ldy, s1_voff;
  si2d_pkg::mode_t mode1, s1_mode;
  logic            s1_vxin;

  always_comb begin
    sa = si2d_pkg::norm_seg(a);
    sb = si2d_pkg::norm_seg(b);
    lp = sa.vert ? sb.p : sa.p;
    vp = sa.vert ? sa.p : sb.p;
    if (sa.vert && sb.vert) begin
      mode1 = si2d_pkg::MODE_BOTH;
    end else if (sa.vert || sb.vert) begin
      mode1 = si2d_pkg::MODE_ONE;
    end else begin
      mode1 = si2d_pkg::MODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a    <= sa;
      s1_b    <= sb;
      s1_l    <= lp;
      s1_v    <= vp;
      s1_adx  <= DXW'(sa.p.x1) - DXW'(sa.p.x0);
      s1_ady  <= DXW'(sa.p.y1) - DXW'(sa.p.y0);
      s1_bdx  <= DXW'(sb.p.x1) - DXW'(sb.p.x0);
      s1_bdy  <= DXW'(sb.p.y1) - DXW'(sb.p.y0);
      s1_ldx  <= DXW'(lp.x1) - DXW'(lp.x0);
      s1_ldy  <= DXW'(lp.y1) - DXW'(lp.y0);
      s1_voff <= DXW'(vp.x0) - DXW'(lp.x0);
      s1_mode <= mode1;
      s1_vxin <= (vp.x0 >= lp.x0) && (vp.x0 <= lp.x1);
    end
  end

  // stage 2: determinant, line constants, vertical-case numerator
  logic signed [DW-1:0]  s2_d;
  logic signed [CAW-1:0] s2_ca, s2_cb;
  logic signed [NW-1:0]  s2_vn;
  si2d_pkg::coord_t      s2_ax0, s2_ax1, s2_bx0, s2_bx1, s2_vy0, s2_vy1, s2_vx;
  si2d_pkg::dx_t         s2_adx, s2_ady, s2_bdx, s2_bdy, s2_ldx;
  si2d_pkg::mode_t       s2_mode;
  logic                  s2_vxin;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d   <= DW'(s1_ady) * DW'(s1_bdx) - DW'(s1_bdy) * DW'(s1_adx);
      s2_ca  <= CAW'(s1_a.p.y0) * CAW'(s1_adx) - CAW'(s1_a.p.x0) * CAW'(s1_ady);
      s2_cb  <= CAW'(s1_b.p.y0) * CAW'(s1_bdx) - CAW'(s1_b.p.x0) * CAW'(s1_bdy);
      s2_vn  <= NW'(s1_l.y0) * NW'(s1_ldx) + NW'(s1_ldy) * NW'(s1_voff);
      s2_ax0 <= s1_a.p.x0;
      s2_ax1 <= s1_a.p.x1;
      s2_bx0 <= s1_b.p.x0;
      s2_bx1 <= s1_b.p.x1;
      s2_vy0 <= s1_v.y0;
      s2_vy1 <= s1_v.y1;
      s2_vx  <= s1_v.x0;
      s2_adx <= s1_adx;
      s2_ady <= s1_ady;
      s2_bdx <= s1_bdx;
      s2_bdy <= s1_bdy;
      s2_ldx <= s1_ldx;
      s2_mode <= s1_mode;
      s2_vxin <= s1_vxin;
    end
  end

  // stage 3: numerators and range bounds scaled by the denominator
  logic signed [NW-1:0] s3_nx, s3_ny, s3_b0, s3_b1, s3_b2, s3_b3;
  logic signed [DW-1:0] s3_d;
  si2d_pkg::mode_t      s3_mode;
  logic                 s3_vxin;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mode <= s2_mode;
      s3_vxin <= s2_vxin;
      if (s2_mode == si2d_pkg::MODE_NONE) begin
        s3_nx <= NW'(s2_cb) * NW'(s2_adx) - NW'(s2_ca) * NW'(s2_bdx);
        s3_ny <= NW'(s2_ady) * NW'(s2_cb) - NW'(s2_bdy) * NW'(s2_ca);
        s3_d  <= s2_d;
        s3_b0 <= NW'(s2_ax0) * NW'(s2_d);
        s3_b1 <= NW'(s2_ax1) * NW'(s2_d);
        s3_b2 <= NW'(s2_bx0) * NW'(s2_d);
        s3_b3 <= NW'(s2_bx1) * NW'(s2_d);
      end else begin
        // x = vx * dx / dx keeps one divider path for both cases
        s3_nx <= NW'(s2_vx) * NW'(s2_ldx);
        s3_ny <= s2_vn;
        s3_d  <= DW'(s2_ldx);
        s3_b0 <= NW'(s2_vy0) * NW'(s2_ldx);
        s3_b1 <= NW'(s2_vy1) * NW'(s2_ldx);
        s3_b2 <= '0;
        s3_b3 <= '0;
      end
    end
  end

  // stage 4: inclusive hit test, sign and magnitude for the dividers
  logic hit4, dneg;
  logic signed [NW-1:0] nx_abs, ny_abs;
  logic signed [DW-1:0] d_abs;

  always_comb begin
    dneg   = s3_d < 0;
    nx_abs = (s3_nx < 0) ? -s3_nx : s3_nx;
    ny_abs = (s3_ny < 0) ? -s3_ny : s3_ny;
    d_abs  = dneg ? -s3_d : s3_d;
    case (s3_mode)
      si2d_pkg::MODE_NONE: begin
        if (dneg) begin
          hit4 = (s3_nx <= s3_b0) && (s3_nx >= s3_b1) &&
                 (s3_nx <= s3_b2) && (s3_nx >= s3_b3);
        end else begin
          hit4 = (s3_d != 0) && (s3_nx >= s3_b0) && (s3_nx <= s3_b1) &&
                 (s3_nx >= s3_b2) && (s3_nx <= s3_b3);
        end
      end
      si2d_pkg::MODE_ONE: begin
        hit4 = s3_vxin && (s3_ny >= s3_b0) && (s3_ny <= s3_b1);
      end
      default: begin
        hit4 = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g.hit   <= hit4;
      g.x_neg <= (s3_nx < 0) ^ dneg;
      g.y_neg <= (s3_ny < 0) ^ dneg;
      g.x_mag <= nx_abs;
      g.y_mag <= ny_abs;
      g.d_mag <= d_abs;
    end
  end
endmodule

### sv/si2d_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module si2d_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [si2d_pkg::NW-1:0]      num,
  input  logic [si2d_pkg::DW-1:0]      den,
  output logic [si2d_pkg::QW-1:0]      quo
);
  localparam int RW = si2d_pkg::RW;
  localparam int QW = si2d_pkg::QW;
  localparam int DW = si2d_pkg::DW;

  logic [RW-1:0] r  [QW];
  logic [DW-1:0] dv [QW];
  logic [QW-1:0] q  [QW];
  logic [RW-1:0] rp [QW];
  logic [DW-1:0] dp [QW];
  logic [QW-1:0] qp [QW];

  // numerator is pre-scaled by the output fraction shift
  assign rp[0] = RW'(num) << si2d_pkg::SH;
  assign dp[0] = den;
  assign qp[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [RW-1:0] trial;
    logic          ge;
    if (i > 0) begin : g_link
      assign rp[i] = r[i-1];
      assign dp[i] = dv[i-1];
      assign qp[i] = q[i-1];
    end
    assign trial = RW'(dp[i]) << (QW - 1 - i);
    assign ge    = rp[i] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        r[i]  <= ge ? (rp[i] - trial) : rp[i];
        dv[i] <= dp[i];
        q[i]  <= qp[i] | (QW'(ge) << (QW - 1 - i));
      end
    end
  end

  assign quo = q[QW-1];
endmodule

### sv/segment_intersection_2d_core.sv
// Top level: 2D segment intersection, stream in, stream out.
//
//  channel  dir  data                                 side
//  s_*      in   tdata 128b: a_x0..b_y1, 16b each     -
//  m_*      out  tdata 56b: cross_x, cross_y          tuser: hit
//
// The pipe has 4 geometry stages, 24 divider stages (one quotient bit each)
// and one output register. One word per cycle is taken while not stalled.
// All stages advance together whenever the output register is empty or
// being taken; a held output freezes the pipe without loss.
// Reset clears only the valid bits; data registers are not reset.
`timescale 1ns / 1ps
`include "segment_intersection_2d_core_assert.svh"
module segment_intersection_2d_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata,   // cross_x [27:0], cross_y [55:28]
  output logic [0:0]   m_tuser    // hit
);
  localparam int CW  = si2d_pkg::CW;
  localparam int OW  = si2d_pkg::OW;
  localparam int QW  = si2d_pkg::QW;
  localparam int LAT = si2d_pkg::LAT;

  logic           en;
  logic [LAT-1:0] vld;
  si2d_pkg::pts_t pa, pb;
  si2d_pkg::geo_t geo;
  si2d_pkg::side_t side [QW];
  logic [QW-1:0]  qx, qy;
  logic [OW-1:0]  ux, uy;

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // unpack the input word, first field lowest
  assign pa.x0 = s_tdata[0*CW +: CW];
  assign pa.y0 = s_tdata[1*CW +: CW];
  assign pa.x1 = s_tdata[2*CW +: CW];
  assign pa.y1 = s_tdata[3*CW +: CW];
  assign pb.x0 = s_tdata[4*CW +: CW];
  assign pb.y0 = s_tdata[5*CW +: CW];
  assign pb.x1 = s_tdata[6*CW +: CW];
  assign pb.y1 = s_tdata[7*CW +: CW];

  si2d_geom u_geom (
    .clk (clk),
    .en  (en),
    .a   (pa),
    .b   (pb),
    .g   (geo)
  );

  si2d_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (geo.x_mag),
    .den (geo.d_mag),
    .quo (qx)
  );

  si2d_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (geo.y_mag),
    .den (geo.d_mag),
    .quo (qy)
  );

  // hit and signs track the divider stages
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{hit: geo.hit, x_neg: geo.x_neg, y_neg: geo.y_neg};
      for (int i = 1; i < QW; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // output word: restore sign, force zero on a miss
  assign ux = OW'(qx);
  assign uy = OW'(qy);

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser[0] <= side[QW-1].hit;
      if (side[QW-1].hit) begin
        m_tdata[OW-1:0]    <= side[QW-1].x_neg ? -ux : ux;
        m_tdata[2*OW-1:OW] <= side[QW-1].y_neg ? -uy : uy;
      end else begin
        m_tdata <= '0;
      end
    end
  end

  `SI2D_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "miss with nonzero coords")
  `SI2D_ASSERT_NEXT(a_stall_freeze, m_tvalid && !m_tready, $stable(vld), "pipe moved while stalled")
  `SI2D_ASSERT_NOW(a_hit_range, m_tvalid && m_tuser[0], (&m_tdata[27:23]) || !(|m_tdata[27:23]), "hit x out of range")
endmodule

### verif/tb_top.sv
// Testbench for the 2D segment intersection core: stream stimulus, predictor scoreboard.
`timescale 1ns / 1ps
module tb_top;

  localparam int LATENCY   = 29;
  localparam int MAX_CYC   = 400000;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic                    hit;
    logic [si2d_pkg::OW-1:0] cx;
    logic [si2d_pkg::OW-1:0] cy;
  } isect_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [55:0]  m_tdata;
  logic [0:0]   m_tuser;

  isect_t isect_q[$];
  int     n_err;
  int     n_words_in;
  int     n_words_out;
  int     n_hits;
  int     cyc;
  bit     src_idle_on;   // random gaps on the input side
  bit     snk_idle_on;   // random stalls on the output side
  int     snk_hold;      // forced long output stall, in cycles

  segment_intersection_2d_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1 (low to high)
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // cross_x, cross_y
    .m_tuser  (m_tuser)    // hit
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // trunc(n * 2^12 / (d * 16)), d > 0, wrapped to the output width
  function automatic logic [si2d_pkg::OW-1:0] q12(longint n, longint d);
    longint den;
    longint q;
    longint r;
    longint v;
    den = d * 16;
    q = n / den;
    r = n % den;
    v = q * 4096 + (r * 4096) / den;
    return v[si2d_pkg::OW-1:0];
  endfunction

  // Order endpoints: x0 <= x1, and y0 <= y1 when vertical.
  function automatic void order_seg(input logic [63:0] raw, output longint x0,
                                    output longint y0, output longint x1,
                                    output longint y1, output bit vert);
    longint t;
    x0 = longint'($signed(raw[15:0]));
    y0 = longint'($signed(raw[31:16]));
    x1 = longint'($signed(raw[47:32]));
    y1 = longint'($signed(raw[63:48]));
    if (x1 < x0) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    vert = (x0 == x1);
    if (vert && y1 < y0) begin
      t = y0; y0 = y1; y1 = t;
    end
  endfunction

  function automatic isect_t predict_isect(logic [127:0] w);
    isect_t r;
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint lx0, ly0, lx1, ly1, vx, vy0, vy1;
    longint dx, dy, n, dxa, dya, dxb, dyb, d, ca, cb, nx, ny;
    bit     av, bv;
    r = '0;
    order_seg(w[63:0], ax0, ay0, ax1, ay1, av);
    order_seg(w[127:64], bx0, by0, bx1, by1, bv);
    if (av && bv) begin
      // both vertical: never a hit
    end else if (av || bv) begin
      if (av) begin
        lx0 = bx0; ly0 = by0; lx1 = bx1; ly1 = by1; vx = ax0; vy0 = ay0; vy1 = ay1;
      end else begin
        lx0 = ax0; ly0 = ay0; lx1 = ax1; ly1 = ay1; vx = bx0; vy0 = by0; vy1 = by1;
      end
      if (vx >= lx0 && vx <= lx1) begin
        dx = lx1 - lx0;
        dy = ly1 - ly0;
        n = ly0 * dx + dy * (vx - lx0);
        if (n >= vy0 * dx && n <= vy1 * dx) begin
          r.hit = 1'b1;
          r.cx = q12(vx, 1);
          r.cy = q12(n, dx);
        end
      end
    end else begin
      dxa = ax1 - ax0; dya = ay1 - ay0;
      dxb = bx1 - bx0; dyb = by1 - by0;
      d = dya * dxb - dyb * dxa;
      if (d != 0) begin
        ca = ay0 * dxa - ax0 * dya;
        cb = by0 * dxb - bx0 * dyb;
        nx = cb * dxa - ca * dxb;
        ny = dya * cb - dyb * ca;
        if (d < 0) begin
          d = -d; nx = -nx; ny = -ny;
        end
        if (nx >= ax0 * d && nx <= ax1 * d && nx >= bx0 * d && nx <= bx1 * d) begin
          r.hit = 1'b1;
          r.cx = q12(nx, d);
          r.cy = q12(ny, d);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] pack_segs(int ax0, int ay0, int ax1, int ay1,
                                            int bx0, int by0, int bx1, int by1);
    return {by1[15:0], bx1[15:0], by0[15:0], bx0[15:0],
            ay1[15:0], ax1[15:0], ay0[15:0], ax0[15:0]};
  endfunction

  // Send one word; holds tvalid until accepted, optional gap before it.
  // tvalid stays high after acceptance so back-to-back words need no gap.
  task automatic send_word(logic [127:0] w);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    isect_q.push_back(predict_isect(w));
    do @(posedge clk); while (!s_tready);
    n_words_in++;
  endtask

  // Wrapper around send_word; leaves tvalid high after the word is taken.
  task automatic send_burst(logic [127:0] w);
    send_word(w);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (isect_q.size() != 0) @(posedge clk);
  endtask

  // Output side: random stall bursts plus a forced long hold.
  initial begin
    int stall;
    m_tready = 1'b0;
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (snk_hold > 0) begin
        snk_hold--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 19) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Scoreboard: each accepted output word against the oldest prediction.
  always @(posedge clk) begin
    isect_t exp_r;
    isect_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[0], m_tdata[27:0], m_tdata[55:28]};
      n_words_out++;
      if (isect_q.size() == 0) begin
        n_err++;
        if (n_err <= MAX_SHOWN)
          $display("ERROR: unexpected result word hit=%0d x=%h y=%h", got.hit, got.cx, got.cy);
      end else begin
        exp_r = isect_q.pop_front();
        if (exp_r.hit) n_hits++;
        if (got !== exp_r) begin
          n_err++;
          if (n_err <= MAX_SHOWN)
            $display("ERROR: word %0d exp hit=%0d x=%h y=%h got hit=%0d x=%h y=%h",
                     n_words_out, exp_r.hit, exp_r.cx, exp_r.cy, got.hit, got.cx, got.cy);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > MAX_CYC) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Corners: extremes of every field, vertical, point, parallel, collinear.
  task automatic test_directed;
    send_word(pack_segs(0, 0, 0, 0, 0, 0, 0, 0));
    send_word(pack_segs(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_word(pack_segs(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
    send_word(pack_segs(-32768, -32768, 32767, 32767, 0, 0, 0, 0));    // point on line
    send_word(pack_segs(0, 0, 160, 160, 0, 160, 160, 0));              // X crossing
    send_word(pack_segs(0, 0, 160, 0, 0, 16, 160, 16));                // parallel
    send_word(pack_segs(0, 0, 160, 160, 32, 32, 320, 320));            // collinear
    send_word(pack_segs(16, -100, 16, 100, 16, 50, 16, 300));          // both vertical, overlap
    send_word(pack_segs(50, 100, 50, -100, 0, 0, 100, 0));             // vertical A, flipped y
    send_word(pack_segs(-10, 5, 90, 7, 40, -20, 40, 20));              // vertical B
    send_word(pack_segs(0, 0, 100, 0, 100, 0, 100, 50));               // touch at x end
    send_word(pack_segs(0, 0, 100, 0, 101, -5, 101, 5));               // just outside
    send_word(pack_segs(0, 0, 100, 0, 50, 1, 50, 9));                  // vertical misses y
    send_word(pack_segs(100, 0, 0, 0, 50, 50, 50, 0));                 // y end inclusive
    send_word(pack_segs(0, 0, 100, 33, 100, 0, 0, 7));                 // fractional result
    send_word(pack_segs(-32768, 32767, 32767, -32768, -32768, 0, 32767, 1));
    send_word(pack_segs(-1, -1, 1, 1, 1, -1, -1, 1));
    send_word(pack_segs(0, 0, 3, 1, 0, 1, 3, 0));
    send_word(pack_segs(-32768, 0, -32768, 0, 32767, 0, 32767, 0));    // two points
    send_word(pack_segs(-5, -7, 9, 3, -6, 4, 8, -11));
  endtask

  function automatic int rnd_coord(int span);
    if (span == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Random pairs; mostly shaped so that crossings are common.
  task automatic test_random(int count);
    logic [127:0] w;
    int span, cx, cy, kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      span = (kind < 2) ? 0 : ((kind < 5) ? 200 : 4000);
      cx = rnd_coord(span / 2);
      cy = rnd_coord(span / 2);
      if (kind == 9) begin
        // one segment vertical through the common area
        w = pack_segs(cx, rnd_coord(span), cx, rnd_coord(span),
                      rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span));
      end else if (kind == 8) begin
        w = {$urandom, $urandom, $urandom, $urandom};
      end else if (kind >= 2) begin
        // endpoints around a shared point: crossing is likely
        w = pack_segs(cx - $urandom_range(0, span), cy - $urandom_range(0, span),
                      cx + $urandom_range(0, span), cy + $urandom_range(0, span),
                      cx - $urandom_range(0, span), cy + $urandom_range(0, span),
                      cx + $urandom_range(0, span), cy - $urandom_range(0, span));
        // Q12.4 fields at the most negative value become the most positive at random
        for (int k = 0; k < 8; k++)
          if (w[16*k +: 16] == 16'h8000 && $urandom_range(0, 1)) w[16*k +: 16] = 16'h7fff;
      end else begin
        w = pack_segs(rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0),
                      rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0));
      end
      send_burst(w);
    end
  endtask

  // Output held off for a long time while the input keeps offering words.
  task automatic test_backpressure;
    snk_hold = 200;
    test_random(80);
    drain();   // input pauses until every result is back
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    n_err = 0; n_words_in = 0; n_words_out = 0; n_hits = 0; cyc = 0;
    src_idle_on = 1'b0; snk_idle_on = 1'b0; snk_hold = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    drain();
    src_idle_on = 1'b1; snk_idle_on = 1'b1;
    test_random(600);
    test_backpressure();
    src_idle_on = 1'b0; snk_idle_on = 1'b0;   // closing stretch at full rate
    test_random(300);

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d segment pairs (%0d results, %0d crossings), directed corners,",
             n_words_in, n_words_out, n_hits);
    $display("random gaps and stalls, a long output hold and a full-rate tail.");
    if (n_err == 0 && isect_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, isect_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
